// ===== design/wsd_pkg.sv =====
`timescale 1ns / 1ps
package wsd_pkg;

  // received byte of a chunk
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } wsd_in_t;

  // one result
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_last;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic       status;
  } wsd_out_t;

  // parser phase
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4,
    PH_SKIP = 3'd5
  } wsd_phase_e;

  // classified work passed from parser to output side
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] mask;
    logic       last;
    logic [3:0] opcode;
    logic       fin;
    logic       status;
  } wsd_job_t;

  // queue status toward the parser and the output side
  typedef struct packed {
    logic full;
    logic valid;
  } wsd_qstat_t;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic STATUS_DATA  = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

endpackage

// ===== design/wsd_front.sv =====
`timescale 1ns / 1ps
module wsd_front
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  wsd_in_t    in_data_i,
  output logic       push_o,
  output wsd_job_t   job_o
);

  wsd_phase_e  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [6:0]  code_q, code_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic        masked_q, masked_d;
  logic [1:0]  idx_q, idx_d;
  logic [3:0]  opc_q, opc_d;
  logic        fin_q, fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      cnt_q    <= '0;
      code_q   <= '0;
      len_q    <= '0;
      key_q    <= '0;
      masked_q <= 1'b0;
      idx_q    <= '0;
      opc_q    <= '0;
      fin_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      code_q   <= code_d;
      len_q    <= len_d;
      key_q    <= key_d;
      masked_q <= masked_d;
      idx_q    <= idx_d;
      opc_q    <= opc_d;
      fin_q    <= fin_d;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic [3:0] need;
    b        = in_data_i.data_byte;
    need     = (code_q == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    code_d   = code_q;
    len_d    = len_q;
    key_d    = key_q;
    masked_d = masked_q;
    idx_d    = idx_q;
    opc_d    = opc_q;
    fin_d    = fin_q;
    push_o   = 1'b0;
    job_o    = '0;
    if (accept_i) begin
      unique case (phase_q)
        PH_HDR0: begin
          fin_d   = b[7];
          opc_d   = b[3:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d = b[7];
          code_d   = b[6:0];
          cnt_d    = '0;
          if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64) begin
            len_d   = '0;
            phase_d = PH_EXT;
          end else begin
            len_d = {57'd0, b[6:0]};
            if (b[7]) begin
              key_d   = '0;
              phase_d = PH_KEY;
            end else begin
              idx_d   = '0;
              phase_d = (b[6:0] == 7'd0) ? PH_SKIP : PH_PAY;
            end
          end
        end
        PH_EXT: begin
          len_d = {len_q[55:0], b};
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= need) begin
            cnt_d = '0;
            if (masked_q) begin
              key_d   = '0;
              phase_d = PH_KEY;
            end else begin
              idx_d   = '0;
              phase_d = (len_d == 64'd0) ? PH_SKIP : PH_PAY;
            end
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], b};
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= KEY_BYTES) begin
            idx_d   = '0;
            phase_d = (len_q == 64'd0) ? PH_SKIP : PH_PAY;
          end
        end
        PH_PAY: begin
          // len_q counts the payload bytes still to come
          push_o      = 1'b1;
          job_o.data  = b;
          job_o.last  = (len_q == 64'd1);
          job_o.status = STATUS_DATA;
          if (masked_q) begin
            unique case (idx_q)
              2'd0: job_o.mask = key_q[31:24];
              2'd1: job_o.mask = key_q[23:16];
              2'd2: job_o.mask = key_q[15:8];
              2'd3: job_o.mask = key_q[7:0];
            endcase
          end
          len_d = len_q - 64'd1;
          idx_d = idx_q + 2'd1;
          if (len_q == 64'd1) begin
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
        end
        default: begin
        end
      endcase
      if (in_data_i.chunk_end) begin
        if (phase_d != PH_SKIP) begin
          // chunk cut the frame short: error replaces any payload byte
          push_o       = 1'b1;
          job_o.data   = '0;
          job_o.mask   = '0;
          job_o.last   = 1'b0;
          job_o.status = STATUS_SHORT;
        end
        phase_d = PH_HDR0;
        cnt_d   = '0;
        idx_d   = '0;
      end
      job_o.opcode = opc_d;
      job_o.fin    = fin_d;
    end
  end

endmodule

// ===== design/wsd_queue.sv =====
`timescale 1ns / 1ps
module wsd_queue
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  wsd_job_t   push_data_i,
  input  logic       pop_i,
  output wsd_job_t   pop_data_o,
  output wsd_qstat_t stat_o
);

  wsd_job_t        mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   count_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == (Q_AW+1)'(Q_DEPTH));
  assign stat_o.valid = (count_q != '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/wsd_back.sv =====
`timescale 1ns / 1ps
module wsd_back
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wsd_qstat_t qstat_i,
  input  wsd_job_t   job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output wsd_out_t   out_data_o
);

  logic     valid_q;
  wsd_out_t data_q;

  // output register refills whenever it is empty or being drained
  assign pop_o       = qstat_i.valid && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q.payload_byte <= job_i.data ^ job_i.mask;
      data_q.payload_last <= job_i.last;
      data_q.frame_opcode <= job_i.opcode;
      data_q.frame_fin    <= job_i.fin;
      data_q.status       <= job_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// ===== design/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// a payload or error result is written into the queue at the transfer of the byte that
//   causes it, then moved into the output register once that register is empty or drained
// throughput: one byte per cycle while the queue has room; the input stalls when it is full
// reset: asynchronous, active low; parser back to the first header byte, queue empty,
//   output register empty
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  wsd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wsd_out_t out_data_o
);

  // parser side: header fields, extended length, mask key, payload classification
  logic       accept;
  logic       push;
  wsd_job_t   push_job;

  // queue between parser and output side
  logic       pop;
  wsd_job_t   pop_job;
  wsd_qstat_t qstat;

  // the parser only stalls when the queue has no room left
  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !in_stall_o;

  wsd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .job_o     (push_job)
  );

  wsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .stat_o      (qstat)
  );

  // output side: unmask and hold the result until its transfer
  wsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // parser never writes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("queue write while full");

  // a held result is never overwritten
  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

  // an empty output register is refilled at once from a waiting queue
  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qstat.valid && !out_valid_o) |-> pop)
    else $error("output register left empty with queued work");

endmodule

// ===== dv/tb_websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;
  localparam int LONG_HOLD   = 60;
  localparam int N_BYTES     = 550;

  // where a chunk ends inside a built frame
  localparam int CUT_NONE   = -1;
  localparam int CUT_RANDOM = -2;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  wsd_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  wsd_out_t out_data_o;

  websocket_frame_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // chunk bytes waiting to be offered, and results still owed by the block
  wsd_in_t  rx_bytes[$];
  wsd_out_t decoded_q[$];

  int n_total  = 0;
  int n_taken  = 0;
  int n_fail   = 0;
  int cycle_cnt;
  logic in_taken = 1'b0;

  // receiver hold-off, counted here so the block backs up into its input
  int   hold_left = 0;
  logic held_once = 1'b0;

  // deframer state as the block should hold it
  wsd_phase_e  frame_ph   = PH_HDR0;
  logic [3:0]  hdr_cnt    = '0;
  logic [6:0]  len_code_q = '0;
  logic [63:0] pay_len    = '0;
  logic [31:0] key_q      = '0;
  logic        masked_q   = 1'b0;
  logic [63:0] pay_idx    = '0;
  logic [3:0]  opcode_q   = '0;
  logic        fin_q      = 1'b0;

  // ---------------------------------------------------------------------------
  // expected behavior
  // ---------------------------------------------------------------------------

  // zero length skips straight to the trailing-byte phase
  task automatic begin_payload();
    pay_idx  = '0;
    frame_ph = (pay_len == 64'd0) ? PH_SKIP : PH_PAY;
  endtask

  task automatic end_of_header();
    hdr_cnt = '0;
    if (masked_q) begin
      key_q    = '0;
      frame_ph = PH_KEY;
    end else begin
      begin_payload();
    end
  endtask

  // advance the parser by one byte and queue whatever result it owes
  task automatic deframe_byte(input wsd_in_t it);
    wsd_out_t   res;
    logic [7:0] b;
    logic [7:0] key_byte;
    logic [3:0] need;
    logic       got;
    int         sel;
    res = '0;
    got = 1'b0;
    b   = it.data_byte;
    case (frame_ph)
      PH_HDR0: begin
        fin_q    = b[7];
        opcode_q = b[3:0];
        frame_ph = PH_HDR1;
      end
      PH_HDR1: begin
        masked_q   = b[7];
        len_code_q = b[6:0];
        hdr_cnt    = '0;
        if (len_code_q == LEN_CODE_16 || len_code_q == LEN_CODE_64) begin
          pay_len  = '0;
          frame_ph = PH_EXT;
        end else begin
          pay_len = {57'd0, len_code_q};
          end_of_header();
        end
      end
      PH_EXT: begin
        // big-endian extended length, top bit taken as is
        need    = (len_code_q == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
        pay_len = {pay_len[55:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= need) end_of_header();
      end
      PH_KEY: begin
        key_q   = {key_q[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= KEY_BYTES) begin_payload();
      end
      PH_PAY: begin
        // first key byte sits in the top of the key register
        sel      = 3 - int'(pay_idx[1:0]);
        key_byte = masked_q ? key_q[8 * sel +: 8] : 8'h00;
        res.payload_byte = b ^ key_byte;
        res.payload_last = (pay_idx == pay_len - 64'd1);
        res.frame_opcode = opcode_q;
        res.frame_fin    = fin_q;
        res.status       = STATUS_DATA;
        got              = 1'b1;
        pay_idx          = pay_idx + 64'd1;
        if (res.payload_last) frame_ph = PH_SKIP;
      end
      default: ;
    endcase
    if (it.chunk_end) begin
      // chunk ran out early: error result, replacing any payload byte of this step
      if (frame_ph != PH_SKIP && frame_ph <= PH_PAY) begin
        res              = '0;
        res.frame_opcode = opcode_q;
        res.frame_fin    = fin_q;
        res.status       = STATUS_SHORT;
        got              = 1'b1;
      end
      frame_ph = PH_HDR0;
      hdr_cnt  = '0;
      pay_idx  = '0;
    end
    if (got) decoded_q = {decoded_q, res};
  endtask

  task automatic check_result(input wsd_out_t got);
    wsd_out_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t: result with none expected, got %h", $time, got);
      n_fail++;
    end else begin
      want = decoded_q.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        $display("%0t: payload_byte expected %h got %h", $time, want.payload_byte,
                 got.payload_byte);
        n_fail++;
      end
      if (got.payload_last !== want.payload_last) begin
        $display("%0t: payload_last expected %b got %b", $time, want.payload_last,
                 got.payload_last);
        n_fail++;
      end
      if (got.frame_opcode !== want.frame_opcode) begin
        $display("%0t: frame_opcode expected %h got %h", $time, want.frame_opcode,
                 got.frame_opcode);
        n_fail++;
      end
      if (got.frame_fin !== want.frame_fin) begin
        $display("%0t: frame_fin expected %b got %b", $time, want.frame_fin, got.frame_fin);
        n_fail++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %b got %b", $time, want.status, got.status);
        n_fail++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] d, input logic last_of_chunk);
    wsd_in_t it;
    it.data_byte = d;
    it.chunk_end = last_of_chunk;
    rx_bytes = {rx_bytes, it};
  endtask

  // one chunk holding a frame; the chunk ends at the last byte, at a given index,
  // or at a random index
  task automatic add_frame(input logic [7:0] b0, input logic mask_bit, input logic [6:0] code,
                           input logic [63:0] plen, input int n_pay, input int n_tail,
                           input int cut);
    logic [7:0] fb[$];
    int         stop;
    fb = {fb, b0};
    fb = {fb, {mask_bit, code}};
    if (code == LEN_CODE_16) begin
      fb = {fb, plen[15:8]};
      fb = {fb, plen[7:0]};
    end else if (code == LEN_CODE_64) begin
      for (int i = 7; i >= 0; i--) fb = {fb, plen[8 * i +: 8]};
    end
    if (mask_bit) repeat (KEY_BYTES) fb = {fb, 8'($urandom_range(0, 255))};
    repeat (n_pay + n_tail) fb = {fb, 8'($urandom_range(0, 255))};
    stop = fb.size() - 1;
    if (cut == CUT_RANDOM) stop = $urandom_range(0, fb.size() - 1);
    else if (cut >= 0 && cut < stop) stop = cut;
    for (int i = 0; i <= stop; i++) push_byte(fb[i], i == stop);
  endtask

  // mostly well-formed frames with random content, some cut short, some plain noise
  task automatic add_random_chunk();
    logic [63:0] plen;
    logic [6:0]  code;
    int          pick;
    int          n_pay;
    int          n_noise;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      n_noise = $urandom_range(1, 6);
      for (int i = 0; i < n_noise; i++)
        push_byte(8'($urandom_range(0, 255)), i == n_noise - 1);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        plen = 64'($urandom_range(0, 12));
        code = plen[6:0];
      end else if (pick < 65) begin
        plen = 64'($urandom_range(13, 125));
        code = plen[6:0];
      end else if (pick < 82) begin
        code = LEN_CODE_16;
        plen = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 65535))
                                           : 64'($urandom_range(0, 30));
      end else begin
        code = LEN_CODE_64;
        plen = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                           : 64'($urandom_range(0, 30));
      end
      // long payloads are never sent whole, only their opening bytes
      n_pay = (plen <= 64'd40) ? int'(plen[7:0]) : int'($urandom_range(0, 8));
      if (plen <= 64'd40 && $urandom_range(0, 99) < 70)
        add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), code, plen, n_pay,
                  int'($urandom_range(0, 3)), CUT_NONE);
      else
        add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), code, plen, n_pay, 0,
                  CUT_RANDOM);
    end
  endtask

  // ---------------------------------------------------------------------------
  // idling schedule: sender light / receiver heavy, then swapped, then none
  // ---------------------------------------------------------------------------

  function automatic int send_gap_pct();
    if (n_taken < n_total / 3) return 13;
    if (n_taken < 2 * n_total / 3) return 45;
    return 0;
  endfunction

  function automatic int recv_gap_pct();
    if (n_taken < n_total / 3) return 45;
    if (n_taken < 2 * n_total / 3) return 13;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offer the next byte once the current one has been transferred
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (rx_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
          in_data_i  <= rx_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off once the sender runs without gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!held_once && n_taken >= 2 * n_total / 3 + 20) begin
        out_stall_i <= 1'b1;
        hold_left   <= LONG_HOLD;
        held_once   <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_gap_pct());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each input transfer, check each output transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(in_data_i);
        n_taken++;
      end
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
    end
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    // directed chunks
    push_byte(8'hFF, 1'b1);                                      // chunk of one header byte
    add_frame(8'h81, 1'b0, 7'd2, 64'd2, 2, 0, CUT_NONE);          // plain frame, ends on last
    add_frame(8'h89, 1'b0, 7'd0, 64'd0, 0, 0, CUT_NONE);          // empty payload
    add_frame(8'h02, 1'b1, 7'd1, 64'd1, 1, 1, CUT_NONE);          // masked, trailing byte
    add_frame(8'h01, 1'b0, LEN_CODE_16, 64'd1, 1, 0, CUT_NONE);   // 16-bit length
    add_frame(8'h00, 1'b1, LEN_CODE_64, '1, 0, 0, 3);             // huge length, cut in ext
    while (rx_bytes.size() < N_BYTES) add_random_chunk();
    n_total = rx_bytes.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (rx_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (n_fail == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
